// ----- sv/yuv420_to_rgb32_block_convert_unit_assert.svh -----
// assertion macros for the yuv420 to rgb32 block converter
// expects clk_i and rst_ni in the scope of the including module
`ifndef YUV420_TO_RGB32_BLOCK_CONVERT_UNIT_ASSERT_SVH
`define YUV420_TO_RGB32_BLOCK_CONVERT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define Y2R_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define Y2R_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define Y2R_ASSERT_NOW(lbl, ante, cons, msg)
`define Y2R_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- sv/y2r_pkg.sv -----
// shared constants for the yuv420 to rgb32 block converter
// no dependencies
package y2r_pkg;

  // default fixed point fraction width
  localparam int unsigned FracBitsDefault = 13;

  // bt.601 coefficients in thousandths
  localparam int unsigned MilliY  = 1164;
  localparam int unsigned MilliBu = 2018;
  localparam int unsigned MilliGu = 391;
  localparam int unsigned MilliGv = 813;
  localparam int unsigned MilliRv = 1596;
  localparam int unsigned MilliOne = 1000;

  // sample offsets and output range
  localparam int unsigned LumaOffset   = 16;
  localparam int unsigned ChromaOffset = 128;
  localparam int unsigned PixMax       = 255;

  // stream geometry
  localparam int unsigned SampleW  = 8;
  localparam int unsigned NumPix   = 4;
  localparam int unsigned NumChan  = 3;
  localparam int unsigned SDataW   = (NumPix + 2) * SampleW;
  localparam int unsigned MDataW   = NumPix * NumChan * SampleW;

  // channel slots within one pixel
  localparam int unsigned ChanBlue  = 0;
  localparam int unsigned ChanGreen = 1;
  localparam int unsigned ChanRed   = 2;

endpackage

// ----- sv/yuv420_to_rgb32_block_convert_unit.sv -----
// yuv420 2x2 block to four bgr pixels, bt.601 fixed point, four-stage pipeline
// depends on y2r_pkg and yuv420_to_rgb32_block_convert_unit_assert.svh
//
// usage:
//   slave channel s_axis_*: one transaction carries a 2x2 luma block and the
//   shared cb/cr pair. master channel m_axis_*: one transaction carries the
//   blue, green and red bytes of the four pixels (no pad byte).
//   an accepted block moves through stages 1, 2, 3 and 4 in order; stage 4 drives
//   m_axis_tvalid_o and m_axis_tdata_o, and the result is taken when the receiver does not stall.
//   throughput: one block per cycle while the receiver does not stall; stage 2 (constant multipliers) and
//   stage 3 (two- and three-input adders) set the clock period.
//   each stage carries its own valid bit and loads whenever it is empty or
//   the stage after it moves, so bubbles are squeezed out during a stall.
//   a stalled receiver holds the result on m_axis_tdata_o; s_axis_tready_o
//   drops only once all four stages hold data.
//   reset clears all valid bits; the pipeline comes up empty and ready.
module yuv420_to_rgb32_block_convert_unit
  import y2r_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = FracBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // luma_tl, luma_tr, luma_bl, luma_br, chroma_u, chroma_v (8 bits each)
  input  logic [SDataW-1:0] s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // blue_tl, green_tl, red_tl, blue_tr, green_tr, red_tr,
  // blue_bl, green_bl, red_bl, blue_br, green_br, red_br (8 bits each)
  output logic [MDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned NumStages = 4;
  // coefficient, product and sum widths follow the fraction width
  // the largest coefficient exceeds 2.0, so a sign bit and two integer bits
  localparam int unsigned CoefW = FRACTION_BITS + 3;
  localparam int unsigned ProdW = FRACTION_BITS + 10;
  localparam int unsigned SumW  = FRACTION_BITS + 11;

  localparam int unsigned KyInt  = ((MilliY  << FRACTION_BITS) + MilliOne / 2) / MilliOne;
  localparam int unsigned KbuInt = ((MilliBu << FRACTION_BITS) + MilliOne / 2) / MilliOne;
  localparam int unsigned KguInt = ((MilliGu << FRACTION_BITS) + MilliOne / 2) / MilliOne;
  localparam int unsigned KgvInt = ((MilliGv << FRACTION_BITS) + MilliOne / 2) / MilliOne;
  localparam int unsigned KrvInt = ((MilliRv << FRACTION_BITS) + MilliOne / 2) / MilliOne;

  localparam logic signed [CoefW-1:0] KyC  = CoefW'(KyInt);
  localparam logic signed [CoefW-1:0] KbuC = CoefW'(KbuInt);
  localparam logic signed [CoefW-1:0] KguC = CoefW'(KguInt);
  localparam logic signed [CoefW-1:0] KgvC = CoefW'(KgvInt);
  localparam logic signed [CoefW-1:0] KrvC = CoefW'(KrvInt);

  // valid bits and per-stage load enables
  logic [NumStages-1:0] vld_q, vld_d, en;

  // stage 1: offset-removed samples
  logic signed [SampleW:0]   y_q  [NumPix];
  logic signed [SampleW:0]   y_d  [NumPix];
  logic signed [SampleW-1:0] u_q, u_d, v_q, v_d;

  // stage 2: products
  logic signed [ProdW-1:0] ly_q [NumPix];
  logic signed [ProdW-1:0] ly_d [NumPix];
  logic signed [ProdW-1:0] bu_q, bu_d, gu_q, gu_d, gv_q, gv_d, rv_q, rv_d;

  // stage 3: channel sums
  logic signed [SumW-1:0] sum_q [NumPix][NumChan];
  logic signed [SumW-1:0] sum_d [NumPix][NumChan];

  // stage 4: clipped output bytes
  logic [SampleW-1:0] pix_q [NumPix][NumChan];
  logic [SampleW-1:0] pix_d [NumPix][NumChan];

  // floor shift then clip to one byte
  function automatic logic [SampleW-1:0] clip_byte(input logic signed [SumW-1:0] s);
    logic signed [SumW-1:0] sh;
    sh = s >>> FRACTION_BITS;
    if (sh[SumW-1]) begin
      return '0;
    end else if (|sh[SumW-2:SampleW]) begin
      return SampleW'(PixMax);
    end else begin
      return sh[SampleW-1:0];
    end
  endfunction

  // load enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || m_axis_tready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d[0] = en[0] ? s_axis_tvalid_i : vld_q[0];
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage 1: unpack and remove offsets
  always_comb begin
    for (int i = 0; i < NumPix; i++) begin
      y_d[i] = $signed({1'b0, s_axis_tdata_i[SampleW*i +: SampleW]})
             - $signed((SampleW+1)'(LumaOffset));
    end
    u_d = $signed(s_axis_tdata_i[SampleW*NumPix +: SampleW] - SampleW'(ChromaOffset));
    v_d = $signed(s_axis_tdata_i[SampleW*(NumPix+1) +: SampleW] - SampleW'(ChromaOffset));
  end

  // stage 2: constant multiplications
  always_comb begin
    for (int i = 0; i < NumPix; i++) begin
      ly_d[i] = ProdW'(KyC) * ProdW'(y_q[i]);
    end
    bu_d = ProdW'(KbuC) * ProdW'(u_q);
    gu_d = ProdW'(KguC) * ProdW'(u_q);
    gv_d = ProdW'(KgvC) * ProdW'(v_q);
    rv_d = ProdW'(KrvC) * ProdW'(v_q);
  end

  // stage 3: per-channel sums
  always_comb begin
    for (int i = 0; i < NumPix; i++) begin
      sum_d[i][ChanBlue]  = SumW'(ly_q[i]) + SumW'(bu_q);
      sum_d[i][ChanGreen] = SumW'(ly_q[i]) - SumW'(gu_q) - SumW'(gv_q);
      sum_d[i][ChanRed]   = SumW'(ly_q[i]) + SumW'(rv_q);
    end
  end

  // stage 4: shift and clip
  always_comb begin
    for (int i = 0; i < NumPix; i++) begin
      for (int c = 0; c < NumChan; c++) begin
        pix_d[i][c] = clip_byte(sum_q[i][c]);
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      y_q <= y_d;
      u_q <= u_d;
      v_q <= v_d;
    end
    if (en[1]) begin
      ly_q <= ly_d;
      bu_q <= bu_d;
      gu_q <= gu_d;
      gv_q <= gv_d;
      rv_q <= rv_d;
    end
    if (en[2]) begin
      sum_q <= sum_d;
    end
    if (en[3]) begin
      pix_q <= pix_d;
    end
  end

  // output packing, blue of the top-left pixel in the lowest byte
  always_comb begin
    for (int i = 0; i < NumPix; i++) begin
      for (int c = 0; c < NumChan; c++) begin
        m_axis_tdata_o[SampleW*(NumChan*i + c) +: SampleW] = pix_q[i][c];
      end
    end
  end

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = vld_q[NumStages-1];

  `include "yuv420_to_rgb32_block_convert_unit_assert.svh"

  // backpressure only when every stage is full and the receiver stalls
  `Y2R_ASSERT_NOW(a_ready_low_full, !s_axis_tready_o,
    (&vld_q) && !m_axis_tready_i, "ready dropped with room in the pipeline")

  // an accepted transaction always lands in stage 1
  `Y2R_ASSERT_NEXT(a_accept_lands, s_axis_tvalid_i && s_axis_tready_o,
    vld_q[0], "accepted transaction lost at stage 1")

  // a held middle stage keeps its item
  `Y2R_ASSERT_NEXT(a_mid_hold, vld_q[1] && !en[2],
    vld_q[1] && vld_q[2], "item dropped while stalled in stage 2")

  // an output left untaken is still there next cycle
  `Y2R_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o, "stalled result vanished")

endmodule

// ----- tb/tb_yuv420_to_rgb32_block_convert_unit.sv -----
// self-checking testbench for the yuv420 2x2 block to bgr pixel converter
// depends on y2r_pkg and yuv420_to_rgb32_block_convert_unit
module tb_yuv420_to_rgb32_block_convert_unit
  import y2r_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned TailCycles = 12;
  localparam int unsigned RandPerPhase = 170;

  // bt.601 coefficients scaled to the fraction width, rounded to nearest
  localparam longint KLuma = ((longint'(MilliY) << FracBitsDefault) + MilliOne / 2) / MilliOne;
  localparam longint KBlueU = ((longint'(MilliBu) << FracBitsDefault) + MilliOne / 2) / MilliOne;
  localparam longint KGreenU = ((longint'(MilliGu) << FracBitsDefault) + MilliOne / 2) / MilliOne;
  localparam longint KGreenV = ((longint'(MilliGv) << FracBitsDefault) + MilliOne / 2) / MilliOne;
  localparam longint KRedV = ((longint'(MilliRv) << FracBitsDefault) + MilliOne / 2) / MilliOne;

  logic              clk_i = 1'b0;
  logic              rst_n = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  // luma_tl, luma_tr, luma_bl, luma_br, chroma_u, chroma_v (8 bits each)
  logic [SDataW-1:0] s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  // blue/green/red of tl, tr, bl, br (8 bits each)
  logic [MDataW-1:0] m_tdata;

  // blocks waiting to be sent and pixel sets waiting to come back
  logic [SDataW-1:0] block_queue[$];
  logic [MDataW-1:0] pixels_due[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned n_blocks = 0;
  int unsigned n_pixsets = 0;
  int unsigned n_errors = 0;
  int unsigned idle_cycles = 0;

  string pos_name[NumPix] = '{"tl", "tr", "bl", "br"};
  string chan_name[NumChan] = '{"blue", "green", "red"};

  yuv420_to_rgb32_block_convert_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // clip a floored fixed point sum to one output byte
  function automatic logic [7:0] clip_to_byte(longint sum);
    longint q;
    q = sum >>> FracBitsDefault;
    if (q < 0) return 8'd0;
    if (q > longint'(PixMax)) return 8'(PixMax);
    return q[7:0];
  endfunction

  // four bgr pixels of one 2x2 block
  function automatic logic [MDataW-1:0] bgr_of_block(logic [SDataW-1:0] blk);
    longint u, v, lum, cb, cg, cr;
    logic [MDataW-1:0] px;
    px = '0;
    u = longint'(blk[NumPix*SampleW +: SampleW]) - longint'(ChromaOffset);
    v = longint'(blk[(NumPix+1)*SampleW +: SampleW]) - longint'(ChromaOffset);
    cb = KBlueU * u;
    cg = KGreenU * u + KGreenV * v;
    cr = KRedV * v;
    for (int p = 0; p < NumPix; p++) begin
      lum = KLuma * (longint'(blk[p*SampleW +: SampleW]) - longint'(LumaOffset));
      px[(p*NumChan + ChanBlue)*SampleW +: SampleW] = clip_to_byte(lum + cb);
      px[(p*NumChan + ChanGreen)*SampleW +: SampleW] = clip_to_byte(lum - cg);
      px[(p*NumChan + ChanRed)*SampleW +: SampleW] = clip_to_byte(lum + cr);
    end
    return px;
  endfunction

  function automatic logic [SDataW-1:0] pack_block(logic [7:0] tl, logic [7:0] tr,
                                                   logic [7:0] bl, logic [7:0] br,
                                                   logic [7:0] u, logic [7:0] v);
    return {v, u, br, bl, tr, tl};
  endfunction

  // sample value, leaning toward offsets and range edges now and then
  function automatic logic [7:0] pick_sample();
    logic [7:0] edges[12] = '{0, 1, 15, 16, 17, 127, 128, 129, 235, 240, 254, 255};
    if ($urandom_range(3) == 0) return edges[$urandom_range(11)];
    return 8'($urandom);
  endfunction

  // sender: next block goes out once the current transaction is taken
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else if (!s_tvalid || s_tready) begin
      if (block_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= block_queue.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // predict on input transactions, check output transactions
  always @(posedge clk_i) begin : check_pixels
    logic [MDataW-1:0] want;
    int unsigned idx;
    if (rst_n) begin
      if (s_tvalid && s_tready) begin
        pixels_due.push_back(bgr_of_block(s_tdata));
        n_blocks++;
      end
      if (m_tvalid && m_tready) begin
        if (pixels_due.size() == 0) begin
          $error("unexpected pixel transaction: %h", m_tdata);
          n_errors++;
        end else begin
          want = pixels_due.pop_front();
          n_pixsets++;
          for (int p = 0; p < NumPix; p++) begin
            for (int c = 0; c < NumChan; c++) begin
              idx = (p * NumChan + c) * SampleW;
              if (m_tdata[idx +: SampleW] !== want[idx +: SampleW]) begin
                $error("%s_%s: expected %0d, got %0d", chan_name[c], pos_name[p],
                       want[idx +: SampleW], m_tdata[idx +: SampleW]);
                n_errors++;
              end
            end
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("tb: timeout, %0d pixel sets still outstanding", pixels_due.size());
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // wait until every queued block is sent and its pixels have come back
  task automatic drain_all();
    while (block_queue.size() != 0 || s_tvalid) @(negedge clk_i);
    while (pixels_due.size() != 0) @(negedge clk_i);
  endtask

  // stimulus
  initial begin
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // directed blocks: range ends, black and white, chroma extremes, clipping
    block_queue.push_back(pack_block(0, 0, 0, 0, 0, 0));
    block_queue.push_back(pack_block(255, 255, 255, 255, 255, 255));
    block_queue.push_back(pack_block(16, 16, 16, 16, 128, 128));
    block_queue.push_back(pack_block(235, 235, 235, 235, 128, 128));
    block_queue.push_back(pack_block(0, 16, 235, 255, 128, 128));
    block_queue.push_back(pack_block(17, 18, 15, 14, 128, 128));
    block_queue.push_back(pack_block(255, 200, 128, 16, 255, 128));
    block_queue.push_back(pack_block(255, 200, 128, 16, 0, 128));
    block_queue.push_back(pack_block(255, 200, 128, 16, 128, 255));
    block_queue.push_back(pack_block(255, 200, 128, 16, 128, 0));
    block_queue.push_back(pack_block(128, 64, 32, 16, 0, 0));
    block_queue.push_back(pack_block(128, 64, 32, 16, 255, 255));
    block_queue.push_back(pack_block(255, 255, 255, 255, 0, 0));
    block_queue.push_back(pack_block(0, 0, 0, 0, 255, 255));
    // small negative sums that floor below zero
    block_queue.push_back(pack_block(16, 16, 17, 17, 127, 127));
    block_queue.push_back(pack_block(16, 17, 16, 17, 129, 129));
    block_queue.push_back(pack_block(8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa));
    block_queue.push_back(pack_block(8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55));
    block_queue.push_back(pack_block(1, 2, 4, 8, 127, 129));
    block_queue.push_back(pack_block(254, 253, 251, 247, 1, 254));
    drain_all();

    // random blocks under each idling pattern, draining between phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int i = 0; i < RandPerPhase; i++) begin
        block_queue.push_back(pack_block(pick_sample(), pick_sample(), pick_sample(),
                                         pick_sample(), pick_sample(), pick_sample()));
        // occasional burst break in the phase without random idling
        if (ph == 0 && i % 40 == 39) drain_all();
      end
      drain_all();
    end

    // let any stray transaction show up before the verdict
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (TailCycles) @(negedge clk_i);

    $display("tb: %0d blocks sent, %0d pixel sets checked under four idling patterns",
             n_blocks, n_pixsets);
    if (n_errors == 0 && pixels_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
